// ===== rtl/core/dhbt_pkg.sv =====
package dhbt_pkg;

    // fixed field widths
    localparam int KEY_W      = 16;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int BKT_OUT_W  = 4;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;

    // default geometry
    localparam int NUM_BUCKETS_DEF  = 11;
    localparam int BUCKET_DEPTH_DEF = 4;

    // command codes, code 3 behaves as a search
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2
    } command_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic load_bucket;
        logic commit;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic out_room;
    } sts_t;

endpackage

// ===== rtl/core/dhbt_ram.sv =====
module dhbt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 11
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/dhbt_ctrl.sv =====
module dhbt_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  dhbt_pkg::sts_t sts,
    output dhbt_pkg::ctl_t ctl
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_REDUCE  = 4'b0010,
        S_READ    = 4'b0100,
        S_COMPARE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // sequencing: accept, reduce key, read row, compare and write back
    always_comb begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        ctl.load_in     = 1'b0;
        ctl.load_bucket = 1'b0;
        ctl.commit      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready    = 1'b1;
                ctl.load_in = in_valid;
                if (in_valid) begin
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE: begin
                ctl.load_bucket = 1'b1;
                state_next      = S_READ;
            end
            S_READ: begin
                state_next = S_COMPARE;
            end
            S_COMPARE: begin
                // hold until the output register can take the result
                if (sts.out_room) begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/dhbt_dp.sv =====
module dhbt_dp #(
    parameter int NUM_BUCKETS  = dhbt_pkg::NUM_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = dhbt_pkg::BUCKET_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dhbt_pkg::ctl_t                  ctl,
    output dhbt_pkg::sts_t                  sts,
    input  logic [dhbt_pkg::CMD_W-1:0]      in_command,
    input  logic [dhbt_pkg::KEY_W-1:0]      in_key,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dhbt_pkg::STATUS_W-1:0]   out_status,
    output logic [dhbt_pkg::BKT_OUT_W-1:0]  out_bucket,
    output logic                            out_found
);

    localparam int KEY_W   = dhbt_pkg::KEY_W;
    localparam int NB_W    = $clog2(NUM_BUCKETS);
    localparam int SHIFT   = KEY_W + NB_W;
    localparam int RECIP_W = KEY_W + 1;
    localparam int PROD_W  = KEY_W + RECIP_W;
    localparam int Q_W     = PROD_W - SHIFT;
    localparam int ROW_W   = KEY_W * BUCKET_DEPTH;
    localparam longint unsigned RECIP_L =
        (longint'(1) << SHIFT) / longint'(NUM_BUCKETS);
    localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_L);
    localparam logic [NB_W:0]      NB_VAL = (NB_W + 1)'(NUM_BUCKETS);

    dhbt_pkg::command_t      cmd_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [NB_W-1:0]         bucket_reg;
    logic [NB_W-1:0]         bucket_next;
    logic [BUCKET_DEPTH-1:0] valid_reg [NUM_BUCKETS];

    logic [Q_W-1:0]          quot;
    logic [KEY_W+1:0]        quot_n;
    logic [KEY_W+1:0]        rem_wide;
    logic [NB_W:0]           rem;
    logic [NB_W:0]           rem_sub;

    logic [ROW_W-1:0]        row_rd;
    logic [ROW_W-1:0]        row_wr;
    logic [BUCKET_DEPTH-1:0] row_valid;
    logic [BUCKET_DEPTH-1:0] match_vec;
    logic [BUCKET_DEPTH-1:0] free_vec;
    logic [BUCKET_DEPTH-1:0] match_oh;
    logic [BUCKET_DEPTH-1:0] free_oh;
    logic [BUCKET_DEPTH-1:0] valid_new;
    logic                    found;
    logic                    has_free;
    logic                    row_we;
    dhbt_pkg::status_t       status;
    logic [NB_W+3:0]         bucket_ext;

    logic                          out_valid_reg;
    logic [dhbt_pkg::STATUS_W-1:0] out_status_reg;
    logic [dhbt_pkg::BKT_OUT_W-1:0] out_bucket_reg;
    logic                          out_found_reg;

    // capture the transaction and start the reciprocal multiply
    always_ff @(posedge aclk) begin
        if (ctl.load_in) begin
            cmd_reg  <= dhbt_pkg::command_t'(in_command);
            key_reg  <= in_key;
            prod_reg <= PROD_W'(in_key) * PROD_W'(RECIP);
        end
    end

    // quotient estimate may be one low, so fix the remainder once
    always_comb begin
        quot     = prod_reg[PROD_W-1:SHIFT];
        quot_n   = (KEY_W + 2)'(quot) * (KEY_W + 2)'(NB_VAL);
        rem_wide = (KEY_W + 2)'(key_reg) - quot_n;
        rem      = rem_wide[NB_W:0];
        rem_sub  = rem - NB_VAL;
        if (rem >= NB_VAL) begin
            bucket_next = rem_sub[NB_W-1:0];
        end else begin
            bucket_next = rem[NB_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_bucket) begin
            bucket_reg <= bucket_next;
        end
    end

    // key rows, one row per bucket
    dhbt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BUCKETS)
    ) u_rows (
        .aclk    (aclk),
        .wr_en   (row_we),
        .wr_addr (bucket_reg),
        .wr_data (row_wr),
        .rd_addr (bucket_reg),
        .rd_data (row_rd)
    );

    // compare every slot of the row, pick lowest match and lowest free slot
    always_comb begin
        row_valid = valid_reg[bucket_reg];
        for (int d = 0; d < BUCKET_DEPTH; d++) begin
            match_vec[d] = row_valid[d] && (row_rd[d*KEY_W +: KEY_W] == key_reg);
            free_vec[d]  = !row_valid[d];
        end
        match_oh = match_vec & (~match_vec + BUCKET_DEPTH'(1));
        free_oh  = free_vec & (~free_vec + BUCKET_DEPTH'(1));
        found    = |match_vec;
        has_free = |free_vec;
        for (int d = 0; d < BUCKET_DEPTH; d++) begin
            row_wr[d*KEY_W +: KEY_W] = free_oh[d] ? key_reg : row_rd[d*KEY_W +: KEY_W];
        end
    end

    // command decode
    always_comb begin
        valid_new = row_valid;
        row_we    = 1'b0;
        case (cmd_reg)
            dhbt_pkg::CMD_INSERT: begin
                if (has_free) begin
                    status    = dhbt_pkg::ST_OK;
                    valid_new = row_valid | free_oh;
                    row_we    = ctl.commit;
                end else begin
                    status = dhbt_pkg::ST_FULL;
                end
            end
            dhbt_pkg::CMD_DELETE: begin
                if (found) begin
                    status    = dhbt_pkg::ST_OK;
                    valid_new = row_valid & ~match_oh;
                end else begin
                    status = dhbt_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                status = found ? dhbt_pkg::ST_OK : dhbt_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // slot valid marks, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                valid_reg[b] <= '0;
            end
        end else if (ctl.commit) begin
            valid_reg[bucket_reg] <= valid_new;
        end
    end

    // output register
    assign bucket_ext = {4'b0000, bucket_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.commit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.commit) begin
            out_status_reg <= status;
            out_bucket_reg <= bucket_ext[dhbt_pkg::BKT_OUT_W-1:0];
            out_found_reg  <= found;
        end
    end

    assign sts.out_room = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_bucket   = out_bucket_reg;
    assign out_found    = out_found_reg;

endmodule

// ===== rtl/core/division_hash_bucket_table.sv =====
// channel  | direction | tdata fields, lowest bit first
// s_       | in        | command [1:0], key [17:2], zero pad [23:18]
// m_       | out       | status [1:0], bucket_index [5:2], found [6], zero pad [7]
//
// each transaction steps through capture with reciprocal multiply, bucket
// remainder, row read from the key ram, then compare and row write-back
// slot valid marks live in flops and are cleared by aresetn, key ram is not
// a waiting result sits in the output register while the next transaction
// is taken; only a still-full output register stalls the compare step
module division_hash_bucket_table #(
    parameter int NUM_BUCKETS  = dhbt_pkg::NUM_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = dhbt_pkg::BUCKET_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dhbt_pkg::S_TDATA_W-1:0]   s_tdata,   // command, key
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dhbt_pkg::M_TDATA_W-1:0]   m_tdata    // status, bucket_index, found
);

    dhbt_pkg::ctl_t                   ctl;
    dhbt_pkg::sts_t                   sts;
    logic [dhbt_pkg::STATUS_W-1:0]    out_status;
    logic [dhbt_pkg::BKT_OUT_W-1:0]   out_bucket;
    logic                             out_found;

    // sequencer
    dhbt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // datapath
    dhbt_dp #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .sts        (sts),
        .in_command (s_tdata[1:0]),
        .in_key     (s_tdata[17:2]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_bucket (out_bucket),
        .out_found  (out_found)
    );

    // result packing
    assign m_tdata = {1'b0, out_found, out_bucket, out_status};

endmodule

// ===== tb/division_hash_bucket_table_tb.sv =====
module division_hash_bucket_table_tb;

    import dhbt_pkg::*;

    localparam int BUCKETS      = NUM_BUCKETS_DEF;
    localparam int DEPTH        = BUCKET_DEPTH_DEF;
    localparam int SLOTS        = BUCKETS * DEPTH;
    localparam int PHASE_ITEMS  = 432;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 20;

    // one expected result transaction
    typedef struct {
        status_t    status;
        logic [3:0] bucket;
        logic       found;
    } table_result_t;

    // tracks table contents and the results still owed by the block
    class bucket_table_scoreboard;
        logic [KEY_W-1:0] slot_key [SLOTS];
        bit               slot_used [SLOTS];
        table_result_t    pending_results [$];
        int               errors;

        function new();
            foreach (slot_used[i]) begin
                slot_used[i] = 1'b0;
                slot_key[i]  = '0;
            end
            errors = 0;
        endfunction

        // predict the result of an accepted command and update the table
        function void note_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
            table_result_t want;
            int bkt;
            int base;
            int hit;
            int hole;
            bkt  = int'(key) % BUCKETS;
            base = bkt * DEPTH;
            hit  = -1;
            hole = -1;
            for (int d = 0; d < DEPTH; d++) begin
                if (slot_used[base + d]) begin
                    if (hit < 0 && slot_key[base + d] == key) hit = d;
                end else if (hole < 0) begin
                    hole = d;
                end
            end
            if (cmd == CMD_INSERT) begin
                if (hole < 0) begin
                    want.status = ST_FULL;
                end else begin
                    slot_key[base + hole]  = key;
                    slot_used[base + hole] = 1'b1;
                    want.status = ST_OK;
                end
            end else if (cmd == CMD_DELETE) begin
                if (hit < 0) begin
                    want.status = ST_NOT_FOUND;
                end else begin
                    slot_used[base + hit] = 1'b0;
                    want.status = ST_OK;
                end
            end else begin
                // search, and the unused code behaves the same
                want.status = (hit < 0) ? ST_NOT_FOUND : ST_OK;
            end
            want.bucket = bkt[3:0];
            want.found  = (hit >= 0);
            pending_results.push_back(want);
        endfunction

        // compare a result transaction with the oldest prediction
        function void check_result(logic [M_TDATA_W-1:0] beat);
            table_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, none expected, got %h", $time, beat);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (beat[1:0] !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, beat[1:0]);
                errors++;
            end
            if (beat[5:2] !== want.bucket) begin
                $display("%0t: bucket_index expected %0d got %0d", $time, want.bucket,
                         beat[5:2]);
                errors++;
            end
            if (beat[6] !== want.found) begin
                $display("%0t: found expected %0d got %0d", $time, want.found, beat[6]);
                errors++;
            end
            if (beat[7] !== 1'b0) begin
                $display("%0t: pad bit expected 0 got %b", $time, beat[7]);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // command, key
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // status, bucket_index, found

    bucket_table_scoreboard table_sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    division_hash_bucket_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watch both channels for completed transactions
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) table_sb.note_command(s_tdata[1:0], s_tdata[17:2]);
            if (m_tvalid && m_tready) table_sb.check_result(m_tdata);
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge aclk) begin
        if (aresetn && !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
            quiet_cycles <= quiet_cycles + 1;
        end else begin
            quiet_cycles <= 0;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // present one command and hold it until taken
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, key, cmd};
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off input until every outstanding result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (table_sb.pending() != 0) @(posedge aclk);
    endtask

    // keys mostly clustered so buckets fill, collide and repeat
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 65) return KEY_W'($urandom_range(BUCKETS - 1) + BUCKETS * $urandom_range(5));
        if (r < 75) return KEY_W'(65535 - BUCKETS * $urandom_range(3) - $urandom_range(10));
        return KEY_W'($urandom_range(65535));
    endfunction

    function automatic logic [CMD_W-1:0] pick_command();
        int r;
        r = $urandom_range(99);
        if (r < 38) return CMD_INSERT;
        if (r < 70) return CMD_DELETE;
        if (r < 95) return CMD_SEARCH;
        return 2'd3;
    endfunction

    task automatic run_phase(int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < PHASE_ITEMS; i++) send_command(pick_command(), pick_key());
        drain_results();
    endtask

    initial begin
        table_sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, filling bucket zero, duplicates, edges of the key
        send_command(CMD_SEARCH, 16'd0);
        send_command(CMD_DELETE, 16'd0);
        send_command(CMD_INSERT, 16'd0);
        send_command(CMD_INSERT, 16'd11);
        send_command(CMD_INSERT, 16'd22);
        send_command(CMD_INSERT, 16'd22);
        send_command(CMD_INSERT, 16'd33);
        send_command(CMD_INSERT, 16'd22);
        send_command(CMD_SEARCH, 16'd22);
        send_command(CMD_DELETE, 16'd22);
        send_command(CMD_SEARCH, 16'd22);
        send_command(CMD_DELETE, 16'd22);
        send_command(CMD_DELETE, 16'd22);
        send_command(CMD_SEARCH, 16'd33);
        send_command(CMD_INSERT, 16'd33);
        send_command(CMD_INSERT, 16'hFFFF);
        send_command(2'd3, 16'hFFFF);
        send_command(CMD_DELETE, 16'hFFFF);
        send_command(2'd3, 16'hFFFF);
        send_command(CMD_INSERT, 16'hAAAA);
        send_command(CMD_SEARCH, 16'h5555);
        send_command(CMD_INSERT, 16'd10);
        send_command(CMD_SEARCH, 16'd10);
        drain_results();

        // random traffic under the four flow-control patterns
        run_phase(0, 0);
        run_phase(81, 0);
        run_phase(0, 81);
        run_phase(22, 22);

        repeat (SETTLE_TICKS) @(posedge aclk);
        if (table_sb.errors == 0 && table_sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
